FILE: rtl/mfsd_pkg.sv
package mfsd_pkg;

  localparam int unsigned MAX_FRAME   = 96;
  localparam int unsigned SLOT_COUNT  = 8;
  localparam int unsigned MAX_REBUILT = 64;

  localparam int unsigned POS_W = 7;

  localparam logic [7:0] SYNC_BYTE    = 8'hAA;
  localparam logic [7:0] TYPE_SINGLE  = 8'h02;
  localparam logic [7:0] TYPE_MULTI   = 8'h03;
  localparam logic [7:0] TYPE_CONTROL = 8'h04;

  localparam logic [7:0] CMD_ANNOUNCE  = 8'h01;
  localparam logic [7:0] CMD_SET_COLOR = 8'h02;

  localparam logic [7:0] LEN_EXTRA_SINGLE  = 8'd4;
  localparam logic [7:0] LEN_EXTRA_MULTI   = 8'd5;
  localparam logic [7:0] LEN_EXTRA_CONTROL = 8'd6;
  localparam logic [7:0] LEN_MIN_SINGLE    = 8'd12;
  localparam logic [7:0] LEN_MIN_MULTI     = 8'd13;
  localparam logic [7:0] LEN_MIN_CONTROL   = 8'd6;

  localparam logic [8:0] REBUILT_EXTRA     = 9'd4;
  localparam logic [7:0] COLOR_MIN_PAYLOAD = 8'd6;
  localparam logic [7:0] DURATION_MIN_LEN  = 8'd2;

  localparam logic [15:0] ANNOUNCE_DEFAULT = 16'd120;
  localparam logic [15:0] ANNOUNCE_MIN     = 16'd20;
  localparam logic [15:0] ANNOUNCE_MAX     = 16'd1000;

  localparam logic [7:0] GAP_LIMIT_RESET = 8'd20;
  localparam logic       MODE_TICK       = 1'b1;

  typedef enum logic [1:0] {
    KIND_SINGLE  = 2'd0,
    KIND_MULTI   = 2'd1,
    KIND_CONTROL = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_RUNNING     = 3'd0,
    ST_OK          = 3'd1,
    ST_UNCHECKED   = 3'd2,
    ST_BAD_SUM     = 3'd3,
    ST_BAD_SLOT    = 3'd4,
    ST_ABORT       = 3'd5,
    ST_BAD_CMD     = 3'd6,
    ST_SHORT_COLOR = 3'd7
  } status_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [9:0]       announce_ms;
    logic [7:0]       command;
    logic [7:0]       slot;
    status_e          status;
    logic             last;
    kind_e            frame_kind;
    logic [POS_W-1:0] position;
    logic [7:0]       out_byte;
  } result_t;

endpackage

FILE: rtl/mfsd_in_reg.sv
module mfsd_in_reg import mfsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  item_t      item_i,
  input  logic       adv_i,
  output logic       fire_o,
  output item_t      item_o
);

  logic  valid_q;
  item_t item_q;

  assign ready_o = !valid_q || adv_i;
  assign fire_o  = valid_q && adv_i;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

FILE: rtl/mfsd_core.sv
module mfsd_core import mfsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  input  logic       fire_i,
  input  item_t      item_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  logic [7:0]       gap_limit_q, gap_limit_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] exp_q, exp_d;
  kind_e            kind_q, kind_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       gap_q, gap_d;
  logic             seen_q, seen_d;
  logic [7:0]       slot_q, slot_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [7:0]       plen_q, plen_d;
  logic [7:0]       dlo_q, dlo_d;
  logic [7:0]       dhi_q, dhi_d;

  logic             restart;
  logic [7:0]       b;
  logic [7:0]       total;
  logic [7:0]       len_extra;
  logic [7:0]       len_min;
  logic             len_step;
  logic             abort;
  logic [15:0]      dur;

  assign b       = item_i.data_byte;
  assign restart = (seen_q && (gap_q > gap_limit_q)) || (pos_q >= POS_W'(MAX_FRAME));

  always_comb begin
    len_extra = LEN_EXTRA_SINGLE;
    len_min   = LEN_MIN_SINGLE;
    len_step  = 1'b0;
    unique case (kind_q)
      KIND_SINGLE: begin
        len_extra = LEN_EXTRA_SINGLE;
        len_min   = LEN_MIN_SINGLE;
        len_step  = (pos_q == POS_W'(2));
      end
      KIND_MULTI: begin
        len_extra = LEN_EXTRA_MULTI;
        len_min   = LEN_MIN_MULTI;
        len_step  = (pos_q == POS_W'(3));
      end
      KIND_CONTROL: begin
        len_extra = LEN_EXTRA_CONTROL;
        len_min   = LEN_MIN_CONTROL;
        len_step  = (pos_q == POS_W'(4));
      end
      default: begin
        len_step = 1'b0;
      end
    endcase
    total = b + len_extra;
  end

  always_comb begin
    gap_limit_d = cfg_we_i ? cfg_data_i : gap_limit_q;
    pos_d  = pos_q;
    exp_d  = exp_q;
    kind_d = kind_q;
    sum_d  = sum_q;
    gap_d  = gap_q;
    seen_d = seen_q;
    slot_d = slot_q;
    cmd_d  = cmd_q;
    plen_d = plen_q;
    dlo_d  = dlo_q;
    dhi_d  = dhi_q;
    abort  = 1'b0;
    dur    = ANNOUNCE_DEFAULT;
    res_valid_o = 1'b0;
    res_o = '{announce_ms: '0, command: '0, slot: '0, status: ST_RUNNING, last: 1'b0,
              frame_kind: KIND_UNKNOWN, position: '0, out_byte: '0};

    if (fire_i) begin
      if (item_i.mode == MODE_TICK) begin
        gap_d = (gap_q == 8'hFF) ? gap_q : gap_q + 8'd1;
      end else begin
        gap_d  = '0;
        seen_d = 1'b1;
        if (restart) begin
          pos_d  = '0;
          exp_d  = '0;
          kind_d = KIND_UNKNOWN;
          sum_d  = '0;
          slot_d = '0;
          cmd_d  = '0;
          plen_d = '0;
          dlo_d  = '0;
          dhi_d  = '0;
        end
        if (!((pos_d == '0) && (b != SYNC_BYTE))) begin
          res_o.position = pos_d;
          res_o.out_byte = b;
          sum_d = sum_d + b;
          pos_d = pos_d + POS_W'(1);
          if (res_o.position == POS_W'(1)) begin
            priority if (b == TYPE_SINGLE) begin
              kind_d = KIND_SINGLE;
            end else if (b == TYPE_MULTI) begin
              kind_d = KIND_MULTI;
            end else if (b == TYPE_CONTROL) begin
              kind_d = KIND_CONTROL;
            end else begin
              abort = 1'b1;
            end
          end else if (res_o.position >= POS_W'(2)) begin
            if (len_step) begin
              if ((total < len_min) || (total > 8'(MAX_FRAME))) begin
                abort = 1'b1;
              end else begin
                exp_d  = total[POS_W-1:0];
                plen_d = b;
              end
            end
            if (kind_d == KIND_MULTI && res_o.position == POS_W'(2)) begin
              slot_d = b;
            end
            if (kind_d == KIND_CONTROL) begin
              if (res_o.position == POS_W'(2)) cmd_d = b;
              if (res_o.position == POS_W'(3)) slot_d = b;
              if (res_o.position == POS_W'(5)) dlo_d = b;
              if (res_o.position == POS_W'(6)) dhi_d = b;
            end
          end

          res_valid_o      = 1'b1;
          res_o.frame_kind = kind_d;
          res_o.slot       = slot_d;
          res_o.command    = cmd_d;

          if (abort) begin
            res_o.last   = 1'b1;
            res_o.status = ST_ABORT;
          end else if ((exp_d == '0) || (pos_d < exp_d)) begin
            res_o.status = ST_RUNNING;
          end else begin
            res_o.last = 1'b1;
            unique case (kind_d)
              KIND_SINGLE: res_o.status = ST_UNCHECKED;
              KIND_MULTI: begin
                priority if (slot_d >= 8'(SLOT_COUNT)) begin
                  res_o.status = ST_BAD_SLOT;
                end else if (sum_q != b) begin
                  res_o.status = ST_BAD_SUM;
                end else if (({1'b0, plen_d} + REBUILT_EXTRA) > 9'(MAX_REBUILT)) begin
                  res_o.status = ST_ABORT;
                end else begin
                  res_o.status = ST_OK;
                end
              end
              default: begin
                if (plen_d >= DURATION_MIN_LEN) dur = {dhi_d, dlo_d};
                if (dur < ANNOUNCE_MIN) dur = ANNOUNCE_MIN;
                if (dur > ANNOUNCE_MAX) dur = ANNOUNCE_MAX;
                priority if (slot_d >= 8'(SLOT_COUNT)) begin
                  res_o.status = ST_BAD_SLOT;
                end else if (sum_q != b) begin
                  res_o.status = ST_BAD_SUM;
                end else if (cmd_d == CMD_ANNOUNCE) begin
                  res_o.status      = ST_OK;
                  res_o.announce_ms = dur[9:0];
                end else if (cmd_d == CMD_SET_COLOR) begin
                  res_o.status = (plen_d < COLOR_MIN_PAYLOAD) ? ST_SHORT_COLOR : ST_OK;
                end else begin
                  res_o.status = ST_BAD_CMD;
                end
              end
            endcase
          end

          if (res_o.last) begin
            pos_d  = '0;
            exp_d  = '0;
            kind_d = KIND_UNKNOWN;
            sum_d  = '0;
            slot_d = '0;
            cmd_d  = '0;
            plen_d = '0;
            dlo_d  = '0;
            dhi_d  = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_limit_q <= GAP_LIMIT_RESET;
      pos_q       <= '0;
      exp_q       <= '0;
      kind_q      <= KIND_UNKNOWN;
      sum_q       <= '0;
      gap_q       <= '0;
      seen_q      <= 1'b0;
      slot_q      <= '0;
      cmd_q       <= '0;
      plen_q      <= '0;
      dlo_q       <= '0;
      dhi_q       <= '0;
    end else begin
      gap_limit_q <= gap_limit_d;
      pos_q       <= pos_d;
      exp_q       <= exp_d;
      kind_q      <= kind_d;
      sum_q       <= sum_d;
      gap_q       <= gap_d;
      seen_q      <= seen_d;
      slot_q      <= slot_d;
      cmd_q       <= cmd_d;
      plen_q      <= plen_d;
      dlo_q       <= dlo_d;
      dhi_q       <= dhi_d;
    end
  end

endmodule

FILE: rtl/mfsd_out_reg.sv
module mfsd_out_reg import mfsd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    res_valid_i,
  input  result_t res_i,
  output logic    adv_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  logic    valid_q;
  result_t res_q;

  assign adv_o   = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

FILE: rtl/multi_format_serial_deframer_top.sv
// Serial frame deframer. Each input transaction carries one received byte or one
// millisecond tick; frames start with 0xAA and a type byte and end with an 8-bit sum.
// Every stored byte comes out as one output transaction with its position, frame
// kind and, on the final byte, the check status and decoded fields. One transaction
// is taken per clock cycle while the output side is not stalled; each result passes
// through the input register and the result register around the frame state update.
module multi_format_serial_deframer_top import mfsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,       // gap_limit_ms
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // data_byte
  input  logic [0:0]  s_axis_tuser_i,   // mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // out_byte, position, status, slot, command, announce_ms
  output logic [1:0]  m_axis_tuser_o,   // frame_kind
  output logic        m_axis_tlast_o
);

  item_t   in_item;
  item_t   item_q;
  logic    fire;
  logic    adv;
  logic    res_valid;
  result_t res;
  result_t res_q;

  assign cfg_ready_o = 1'b1;
  assign in_item     = '{mode: s_axis_tuser_i[0], data_byte: s_axis_tdata_i};

  mfsd_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (in_item),
    .adv_i   (adv),
    .fire_o  (fire),
    .item_o  (item_q)
  );

  mfsd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (fire),
    .item_i      (item_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mfsd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .adv_o       (adv),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .res_o       (res_q)
  );

  assign m_axis_tdata_o = {4'b0, res_q.announce_ms, res_q.command, res_q.slot,
                           res_q.status, res_q.position, res_q.out_byte};
  assign m_axis_tuser_o = res_q.frame_kind;
  assign m_axis_tlast_o = res_q.last;

  a_running_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> res_q.status == ST_RUNNING)
    else $error("running result without final status");

  a_unknown_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res_q.frame_kind == KIND_UNKNOWN |->
      res_q.status == ST_RUNNING || res_q.status == ST_ABORT)
    else $error("unknown frame kind with frame-end status");

  a_announce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res_q.announce_ms != '0 |->
      res_q.status == ST_OK && res_q.frame_kind == KIND_CONTROL && res_q.last)
    else $error("announce duration outside an ok control frame end");

  a_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> res_q.position < POS_W'(MAX_FRAME))
    else $error("position beyond frame limit");

endmodule
